// ----- rtl/csmc_pkg.sv -----
// ----------------------------------------------------------------------------
// csmc_pkg: shared types and constants for the clock-set menu controller
// Key and mode codes, the request and result records, and BCD helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csmc_pkg;

  localparam int BCD_W  = 8;
  localparam int MODE_W = 3;
  localparam int KEY_W  = 3;
  localparam int BIN_W  = 7;  // binary value of a field, 0..99

  localparam logic [KEY_W-1:0] KEY_MENU   = 3'd1;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 3'd2;
  localparam logic [KEY_W-1:0] KEY_UP     = 3'd3;
  localparam logic [KEY_W-1:0] KEY_DN     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_YEAR    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MONTH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DAY     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WEEKDAY = 3'd4;
  localparam logic [MODE_W-1:0] MODE_HOUR    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MINUTE  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_LAST    = MODE_MINUTE;

  localparam logic [BCD_W-1:0] RST_YEAR    = 8'h00;
  localparam logic [BCD_W-1:0] RST_MONTH   = 8'h01;
  localparam logic [BCD_W-1:0] RST_DAY     = 8'h01;
  localparam logic [BCD_W-1:0] RST_WEEKDAY = 8'h01;
  localparam logic [BCD_W-1:0] RST_HOUR    = 8'h00;
  localparam logic [BCD_W-1:0] RST_MINUTE  = 8'h00;
  localparam logic [BCD_W-1:0] RST_SECOND  = 8'h00;
  localparam logic [BCD_W-1:0] BCD_ZERO    = 8'h00;

  localparam logic [BIN_W-1:0] YEAR_LO    = 7'd0;
  localparam logic [BIN_W-1:0] YEAR_HI    = 7'd99;
  localparam logic [BIN_W-1:0] MONTH_LO   = 7'd1;
  localparam logic [BIN_W-1:0] MONTH_HI   = 7'd12;
  localparam logic [BIN_W-1:0] DAY_LO     = 7'd1;
  localparam logic [BIN_W-1:0] DAY_HI     = 7'd31;
  localparam logic [BIN_W-1:0] WEEKDAY_LO = 7'd1;
  localparam logic [BIN_W-1:0] WEEKDAY_HI = 7'd7;
  localparam logic [BIN_W-1:0] HOUR_LO    = 7'd0;
  localparam logic [BIN_W-1:0] HOUR_HI    = 7'd23;
  localparam logic [BIN_W-1:0] MINUTE_LO  = 7'd0;
  localparam logic [BIN_W-1:0] MINUTE_HI  = 7'd59;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key_code;
    logic [BCD_W-1:0]  year;
    logic [BCD_W-1:0]  month;
    logic [BCD_W-1:0]  day;
    logic [BCD_W-1:0]  weekday;
    logic [BCD_W-1:0]  hour;
    logic [BCD_W-1:0]  minute;
    logic [BCD_W-1:0]  second;
  } req_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BCD_W-1:0]  year;
    logic [BCD_W-1:0]  month;
    logic [BCD_W-1:0]  day;
    logic [BCD_W-1:0]  weekday;
    logic [BCD_W-1:0]  hour;
    logic [BCD_W-1:0]  minute;
    logic [BCD_W-1:0]  second;
    logic              commit;
  } res_t;

  // Binary to BCD for 0..99: tens by reciprocal multiply (205/2048 ~ 1/10).
  function automatic logic [BCD_W-1:0] to_bcd(input logic [BIN_W-1:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [BIN_W-1:0] ones;
    prod = 18'(v) * 18'd205;
    tens = prod[14:11];
    ones = v - BIN_W'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/csmc_in_reg.sv -----
// ----------------------------------------------------------------------------
// csmc_in_reg: request capture register
// Holds one request until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csmc_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          take,
  input  wire csmc_pkg::req_t req_in,
  output logic               in_stall,
  output logic               req_valid,
  output csmc_pkg::req_t     req_out
);

  logic           valid_r;
  logic           valid_nxt;
  csmc_pkg::req_t req_r;

  // Stall only while a held request cannot move on.
  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= req_in;
    end
  end

  assign req_valid = valid_r;
  assign req_out   = req_r;

endmodule

`default_nettype wire

// ----- rtl/csmc_field_step.sv -----
// ----------------------------------------------------------------------------
// csmc_field_step: decimal up/down step of one BCD field
// Wraps within [lo, hi]; a value (invalid BCD read as 10*high + low) outside the range snaps to the range end.
// ----------------------------------------------------------------------------
`default_nettype none

module csmc_field_step (
  input  wire logic [csmc_pkg::BCD_W-1:0] fld,
  input  wire logic [csmc_pkg::BIN_W-1:0] lo,
  input  wire logic [csmc_pkg::BIN_W-1:0] hi,
  input  wire logic                       up,
  output logic      [csmc_pkg::BCD_W-1:0] fld_nxt
);

  logic [7:0]                  val;
  logic [csmc_pkg::BIN_W-1:0]  res;

  // Read nibbles as 10*high + low, up to 165.
  assign val = 8'(fld[7:4]) * 8'd10 + 8'(fld[3:0]);

  always_comb begin
    if (up) begin
      if (val >= 8'(hi) || val < 8'(lo)) begin
        res = lo;
      end else begin
        res = val[csmc_pkg::BIN_W-1:0] + 7'd1;
      end
    end else begin
      if (val <= 8'(lo) || val > 8'(hi)) begin
        res = hi;
      end else begin
        res = val[csmc_pkg::BIN_W-1:0] - 7'd1;
      end
    end
  end

  assign fld_nxt = csmc_pkg::to_bcd(res);

endmodule

`default_nettype wire

// ----- rtl/csmc_state.sv -----
// ----------------------------------------------------------------------------
// csmc_state: edit mode and BCD time registers
// Applies one request to the state and presents the post-update values.
// ----------------------------------------------------------------------------
`default_nettype none

module csmc_state (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           upd,
  input  wire csmc_pkg::req_t req,
  output csmc_pkg::res_t      res_nxt
);

  logic [csmc_pkg::MODE_W-1:0] mode_r,    mode_nxt;
  logic [csmc_pkg::BCD_W-1:0]  year_r,    year_nxt;
  logic [csmc_pkg::BCD_W-1:0]  month_r,   month_nxt;
  logic [csmc_pkg::BCD_W-1:0]  day_r,     day_nxt;
  logic [csmc_pkg::BCD_W-1:0]  weekday_r, weekday_nxt;
  logic [csmc_pkg::BCD_W-1:0]  hour_r,    hour_nxt;
  logic [csmc_pkg::BCD_W-1:0]  minute_r,  minute_nxt;
  logic [csmc_pkg::BCD_W-1:0]  second_r,  second_nxt;
  logic                        commit;

  logic [csmc_pkg::BCD_W-1:0]  sel_fld;
  logic [csmc_pkg::BIN_W-1:0]  sel_lo;
  logic [csmc_pkg::BIN_W-1:0]  sel_hi;
  logic [csmc_pkg::BCD_W-1:0]  step_fld;
  logic                        is_step;

  // Pick the field and range that the current mode edits.
  always_comb begin
    unique case (mode_r)
      csmc_pkg::MODE_YEAR: begin
        sel_fld = year_r;    sel_lo = csmc_pkg::YEAR_LO;    sel_hi = csmc_pkg::YEAR_HI;
      end
      csmc_pkg::MODE_MONTH: begin
        sel_fld = month_r;   sel_lo = csmc_pkg::MONTH_LO;   sel_hi = csmc_pkg::MONTH_HI;
      end
      csmc_pkg::MODE_DAY: begin
        sel_fld = day_r;     sel_lo = csmc_pkg::DAY_LO;     sel_hi = csmc_pkg::DAY_HI;
      end
      csmc_pkg::MODE_WEEKDAY: begin
        sel_fld = weekday_r; sel_lo = csmc_pkg::WEEKDAY_LO; sel_hi = csmc_pkg::WEEKDAY_HI;
      end
      csmc_pkg::MODE_HOUR: begin
        sel_fld = hour_r;    sel_lo = csmc_pkg::HOUR_LO;    sel_hi = csmc_pkg::HOUR_HI;
      end
      csmc_pkg::MODE_MINUTE: begin
        sel_fld = minute_r;  sel_lo = csmc_pkg::MINUTE_LO;  sel_hi = csmc_pkg::MINUTE_HI;
      end
      default: begin
        sel_fld = year_r;    sel_lo = csmc_pkg::YEAR_LO;    sel_hi = csmc_pkg::YEAR_HI;
      end
    endcase
  end

  csmc_field_step u_step (
    .fld     (sel_fld),
    .lo      (sel_lo),
    .hi      (sel_hi),
    .up      (req.key_code == csmc_pkg::KEY_UP),
    .fld_nxt (step_fld)
  );

  assign is_step = !req.req_type &&
                   (req.key_code == csmc_pkg::KEY_UP || req.key_code == csmc_pkg::KEY_DN);

  always_comb begin
    mode_nxt    = mode_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    weekday_nxt = weekday_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    commit      = 1'b0;
    if (req.req_type) begin
      year_nxt    = req.year;
      month_nxt   = req.month;
      day_nxt     = req.day;
      weekday_nxt = req.weekday;
      hour_nxt    = req.hour;
      minute_nxt  = req.minute;
      second_nxt  = req.second;
    end else if (req.key_code == csmc_pkg::KEY_MENU) begin
      if (mode_r == csmc_pkg::MODE_LAST) begin
        mode_nxt   = csmc_pkg::MODE_NORMAL;
        second_nxt = csmc_pkg::BCD_ZERO;
        commit     = 1'b1;
      end else begin
        mode_nxt = mode_r + 3'd1;  // wraps to normal from the unused code
      end
    end else if (req.key_code == csmc_pkg::KEY_CANCEL) begin
      mode_nxt = csmc_pkg::MODE_NORMAL;
    end else if (is_step) begin
      unique case (mode_r)
        csmc_pkg::MODE_YEAR:    year_nxt    = step_fld;
        csmc_pkg::MODE_MONTH:   month_nxt   = step_fld;
        csmc_pkg::MODE_DAY:     day_nxt     = step_fld;
        csmc_pkg::MODE_WEEKDAY: weekday_nxt = step_fld;
        csmc_pkg::MODE_HOUR:    hour_nxt    = step_fld;
        csmc_pkg::MODE_MINUTE:  minute_nxt  = step_fld;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= csmc_pkg::MODE_NORMAL;
      year_r    <= csmc_pkg::RST_YEAR;
      month_r   <= csmc_pkg::RST_MONTH;
      day_r     <= csmc_pkg::RST_DAY;
      weekday_r <= csmc_pkg::RST_WEEKDAY;
      hour_r    <= csmc_pkg::RST_HOUR;
      minute_r  <= csmc_pkg::RST_MINUTE;
      second_r  <= csmc_pkg::RST_SECOND;
    end else if (upd) begin
      mode_r    <= mode_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      weekday_r <= weekday_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
    end
  end

  assign res_nxt = '{mode:    mode_nxt,
                     year:    year_nxt,
                     month:   month_nxt,
                     day:     day_nxt,
                     weekday: weekday_nxt,
                     hour:    hour_nxt,
                     minute:  minute_nxt,
                     second:  second_nxt,
                     commit:  commit};

endmodule

`default_nettype wire

// ----- rtl/clock_set_menu_controller_top.sv -----
// Pipeline: an accepted request is held in the input register, then its result is
// written to the result register, which raises out_valid; the mode and BCD update
// is combinational. Throughput: one request per cycle while out_stall is low.
// in_stall rises only while a request is held and the held result is stalled.
// Reset (rst_n low, synchronous): mode normal, time 00-01-01 weekday 1, 00:00:00,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// clock_set_menu_controller_top: clock-set menu key handler
// Edit mode sequencing, BCD field stepping, time load and commit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_set_menu_controller_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [csmc_pkg::KEY_W-1:0]  in_key_code,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_year,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_month,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_day,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_weekday,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_hour,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_minute,
  input  wire logic [csmc_pkg::BCD_W-1:0]  in_load_second,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [csmc_pkg::MODE_W-1:0]      out_edit_mode,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_year,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_month,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_day,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_weekday,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_hour,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_minute,
  output logic [csmc_pkg::BCD_W-1:0]       out_cur_second,
  output logic                             out_commit_time
);

  csmc_pkg::req_t req_in;
  csmc_pkg::req_t req_q;
  logic           req_valid;
  logic           out_free;
  logic           advance;
  csmc_pkg::res_t res_nxt;
  csmc_pkg::res_t res_r;
  logic           out_valid_r;
  logic           out_valid_nxt;

  assign req_in = '{req_type: in_req_type,
                    key_code: in_key_code,
                    year:     in_load_year,
                    month:    in_load_month,
                    day:      in_load_day,
                    weekday:  in_load_weekday,
                    hour:     in_load_hour,
                    minute:   in_load_minute,
                    second:   in_load_second};

  assign out_free = !(out_valid_r && out_stall);
  assign advance  = req_valid && out_free;

  csmc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .take      (out_free),
    .req_in    (req_in),
    .in_stall  (in_stall),
    .req_valid (req_valid),
    .req_out   (req_q)
  );

  csmc_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (advance),
    .req     (req_q),
    .res_nxt (res_nxt)
  );

  // Hold the result while stalled, drop it once taken.
  assign out_valid_nxt = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edit_mode   = res_r.mode;
  assign out_cur_year    = res_r.year;
  assign out_cur_month   = res_r.month;
  assign out_cur_day     = res_r.day;
  assign out_cur_weekday = res_r.weekday;
  assign out_cur_hour    = res_r.hour;
  assign out_cur_minute  = res_r.minute;
  assign out_cur_second  = res_r.second;
  assign out_commit_time = res_r.commit;

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.commit |->
      res_r.mode == csmc_pkg::MODE_NORMAL && res_r.second == csmc_pkg::BCD_ZERO)
    else $error("commit without return to normal mode and cleared seconds");

  a_mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.mode <= csmc_pkg::MODE_LAST)
    else $error("edit mode beyond the last field");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request did not reach the result register");

  a_stall_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_valid && !out_free)
    else $error("input stalled with no blocked request");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: clock-set menu controller
// Drives key and time-load requests through the valid/stall input channel,
// predicts the mode, BCD registers and commit flag after every request, and
// compares each readout on the result channel in order. Both sides idle and
// stall in random bursts except during the full-rate tail of the run.
// ----------------------------------------------------------------------------

module testbench;

  localparam logic                       REQ_KEY          = 1'b0;
  localparam logic                       REQ_LOAD         = 1'b1;
  localparam logic [csmc_pkg::KEY_W-1:0] KEY_NONE         = 3'd0;
  localparam logic [csmc_pkg::KEY_W-1:0] KEY_UNUSED_FIRST = 3'd5;
  localparam logic [csmc_pkg::KEY_W-1:0] KEY_UNUSED_LAST  = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_req_type;
  logic [csmc_pkg::KEY_W-1:0]  in_key_code;
  logic [csmc_pkg::BCD_W-1:0]  in_load_year;
  logic [csmc_pkg::BCD_W-1:0]  in_load_month;
  logic [csmc_pkg::BCD_W-1:0]  in_load_day;
  logic [csmc_pkg::BCD_W-1:0]  in_load_weekday;
  logic [csmc_pkg::BCD_W-1:0]  in_load_hour;
  logic [csmc_pkg::BCD_W-1:0]  in_load_minute;
  logic [csmc_pkg::BCD_W-1:0]  in_load_second;
  logic                        out_valid;
  logic                        out_stall;
  logic [csmc_pkg::MODE_W-1:0] out_edit_mode;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_year;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_month;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_day;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_weekday;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_hour;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_minute;
  logic [csmc_pkg::BCD_W-1:0]  out_cur_second;
  logic                        out_commit_time;

  csmc_pkg::res_t clock_now;
  csmc_pkg::res_t due_readouts[$];
  int unsigned    bad_fields = 0;
  bit             idle_on = 1'b1;

  clock_set_menu_controller_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_key_code     (in_key_code),
    .in_load_year    (in_load_year),
    .in_load_month   (in_load_month),
    .in_load_day     (in_load_day),
    .in_load_weekday (in_load_weekday),
    .in_load_hour    (in_load_hour),
    .in_load_minute  (in_load_minute),
    .in_load_second  (in_load_second),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_edit_mode   (out_edit_mode),
    .out_cur_year    (out_cur_year),
    .out_cur_month   (out_cur_month),
    .out_cur_day     (out_cur_day),
    .out_cur_weekday (out_cur_weekday),
    .out_cur_hour    (out_cur_hour),
    .out_cur_minute  (out_cur_minute),
    .out_cur_second  (out_cur_second),
    .out_commit_time (out_commit_time)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [csmc_pkg::BCD_W-1:0] bcd_of(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Out-of-range contents (non-decimal nibbles read as 10*high + low) snap to the far end of the range.
  function automatic logic [csmc_pkg::BCD_W-1:0] step_bcd(
      input logic [csmc_pkg::BCD_W-1:0] b, input int lo, input int hi, input bit up);
    int v;
    int r;
    v = b[7:4] * 10 + b[3:0];
    if (up) r = (v >= hi || v < lo) ? lo : v + 1;
    else    r = (v <= lo || v > hi) ? hi : v - 1;
    return bcd_of(r);
  endfunction

  function automatic csmc_pkg::res_t step_menu(input csmc_pkg::req_t r);
    csmc_pkg::res_t nxt;
    bit             up;
    nxt = clock_now;
    nxt.commit = 1'b0;
    up = (r.key_code == csmc_pkg::KEY_UP);
    if (r.req_type == REQ_LOAD) begin
      nxt.year    = r.year;
      nxt.month   = r.month;
      nxt.day     = r.day;
      nxt.weekday = r.weekday;
      nxt.hour    = r.hour;
      nxt.minute  = r.minute;
      nxt.second  = r.second;
    end else begin
      unique case (r.key_code)
        csmc_pkg::KEY_MENU: begin
          if (nxt.mode == csmc_pkg::MODE_LAST) begin
            nxt.mode   = csmc_pkg::MODE_NORMAL;
            nxt.second = csmc_pkg::BCD_ZERO;
            nxt.commit = 1'b1;
          end else begin
            nxt.mode = nxt.mode + 1'b1;
          end
        end
        csmc_pkg::KEY_CANCEL: nxt.mode = csmc_pkg::MODE_NORMAL;
        csmc_pkg::KEY_UP, csmc_pkg::KEY_DN: begin
          unique case (nxt.mode)
            csmc_pkg::MODE_YEAR:
              nxt.year = step_bcd(nxt.year, int'(csmc_pkg::YEAR_LO),
                                  int'(csmc_pkg::YEAR_HI), up);
            csmc_pkg::MODE_MONTH:
              nxt.month = step_bcd(nxt.month, int'(csmc_pkg::MONTH_LO),
                                   int'(csmc_pkg::MONTH_HI), up);
            csmc_pkg::MODE_DAY:
              nxt.day = step_bcd(nxt.day, int'(csmc_pkg::DAY_LO),
                                 int'(csmc_pkg::DAY_HI), up);
            csmc_pkg::MODE_WEEKDAY:
              nxt.weekday = step_bcd(nxt.weekday, int'(csmc_pkg::WEEKDAY_LO),
                                     int'(csmc_pkg::WEEKDAY_HI), up);
            csmc_pkg::MODE_HOUR:
              nxt.hour = step_bcd(nxt.hour, int'(csmc_pkg::HOUR_LO),
                                  int'(csmc_pkg::HOUR_HI), up);
            csmc_pkg::MODE_MINUTE:
              nxt.minute = step_bcd(nxt.minute, int'(csmc_pkg::MINUTE_LO),
                                    int'(csmc_pkg::MINUTE_HI), up);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    clock_now = nxt;
    return nxt;
  endfunction

  // ---------------------------------------------------------------- requests

  function automatic csmc_pkg::req_t make_raw_load();
    csmc_pkg::req_t r;
    r.req_type = REQ_LOAD;
    r.key_code = 3'($urandom_range(KEY_NONE, KEY_UNUSED_LAST));
    r.year     = 8'($urandom_range(0, 255));
    r.month    = 8'($urandom_range(0, 255));
    r.day      = 8'($urandom_range(0, 255));
    r.weekday  = 8'($urandom_range(0, 255));
    r.hour     = 8'($urandom_range(0, 255));
    r.minute   = 8'($urandom_range(0, 255));
    r.second   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Load fields of a key request are don't-care; keep them random.
  function automatic csmc_pkg::req_t make_key(input logic [csmc_pkg::KEY_W-1:0] key);
    csmc_pkg::req_t r;
    r = make_raw_load();
    r.req_type = REQ_KEY;
    r.key_code = key;
    return r;
  endfunction

  function automatic csmc_pkg::req_t make_load(input int y, input int mo, input int d,
                                               input int w, input int h, input int mi,
                                               input int s);
    csmc_pkg::req_t r;
    r = make_raw_load();
    r.year    = bcd_of(y);
    r.month   = bcd_of(mo);
    r.day     = bcd_of(d);
    r.weekday = bcd_of(w);
    r.hour    = bcd_of(h);
    r.minute  = bcd_of(mi);
    r.second  = bcd_of(s);
    return r;
  endfunction

  // Favor the ends of each range so wraps come up often.
  function automatic int pick_value(input int lo, input int hi);
    unique case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic csmc_pkg::req_t make_time_load();
    return make_load(pick_value(int'(csmc_pkg::YEAR_LO), int'(csmc_pkg::YEAR_HI)),
                     pick_value(int'(csmc_pkg::MONTH_LO), int'(csmc_pkg::MONTH_HI)),
                     pick_value(int'(csmc_pkg::DAY_LO), int'(csmc_pkg::DAY_HI)),
                     pick_value(int'(csmc_pkg::WEEKDAY_LO), int'(csmc_pkg::WEEKDAY_HI)),
                     pick_value(int'(csmc_pkg::HOUR_LO), int'(csmc_pkg::HOUR_HI)),
                     pick_value(int'(csmc_pkg::MINUTE_LO), int'(csmc_pkg::MINUTE_HI)),
                     pick_value(int'(csmc_pkg::MINUTE_LO), int'(csmc_pkg::MINUTE_HI)));
  endfunction

  function automatic csmc_pkg::req_t make_ignored_key();
    if ($urandom_range(0, 3) == 0) return make_key(KEY_NONE);
    return make_key(3'($urandom_range(KEY_UNUSED_FIRST, KEY_UNUSED_LAST)));
  endfunction

  // Valid stays high on return unless an idle burst was taken; callers either
  // send again in the same step or go through drain_results.
  task automatic send_request(input csmc_pkg::req_t r);
    in_valid        <= 1'b1;
    in_req_type     <= r.req_type;
    in_key_code     <= r.key_code;
    in_load_year    <= r.year;
    in_load_month   <= r.month;
    in_load_day     <= r.day;
    in_load_weekday <= r.weekday;
    in_load_hour    <= r.hour;
    in_load_minute  <= r.minute;
    in_load_second  <= r.second;
    do @(posedge clk); while (in_stall);
    due_readouts.push_back(step_menu(r));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_readouts.size() != 0);
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name,
                                      input logic [csmc_pkg::BCD_W-1:0] want,
                                      input logic [csmc_pkg::BCD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      bad_fields++;
    end
  endfunction

  always @(posedge clk) begin : readout_check
    csmc_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_readouts.size() == 0) begin
        $display("%0t: readout with no request pending, expected none, got mode %0h",
                 $time, out_edit_mode);
        bad_fields++;
      end else begin
        want = due_readouts.pop_front();
        check_field("edit_mode", 8'(want.mode), 8'(out_edit_mode));
        check_field("cur_year", want.year, out_cur_year);
        check_field("cur_month", want.month, out_cur_month);
        check_field("cur_day", want.day, out_cur_day);
        check_field("cur_weekday", want.weekday, out_cur_weekday);
        check_field("cur_hour", want.hour, out_cur_hour);
        check_field("cur_minute", want.minute, out_cur_minute);
        check_field("cur_second", want.second, out_cur_second);
        check_field("commit_time", 8'(want.commit), 8'(out_commit_time));
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_request(make_key(KEY_NONE));
  endtask

  task automatic test_ignored_keys();
    for (int k = KEY_UNUSED_FIRST; k <= KEY_UNUSED_LAST; k++)
      send_request(make_key(3'(k)));
  endtask

  // Start every field at its top, then wrap up and back down in each mode.
  task automatic test_field_wrap();
    csmc_pkg::req_t r;
    r = make_load(int'(csmc_pkg::YEAR_HI), int'(csmc_pkg::MONTH_HI),
                  int'(csmc_pkg::DAY_HI), int'(csmc_pkg::WEEKDAY_HI),
                  int'(csmc_pkg::HOUR_HI), int'(csmc_pkg::MINUTE_HI),
                  int'(csmc_pkg::MINUTE_HI));
    r.key_code = csmc_pkg::KEY_MENU;
    send_request(r);
    for (int m = csmc_pkg::MODE_YEAR; m <= csmc_pkg::MODE_LAST; m++) begin
      send_request(make_key(csmc_pkg::KEY_MENU));
      send_request(make_key(csmc_pkg::KEY_UP));
      send_request(make_key(csmc_pkg::KEY_DN));
    end
    send_request(make_key(csmc_pkg::KEY_MENU));
  endtask

  task automatic test_invalid_bcd();
    csmc_pkg::req_t r;
    r = make_raw_load();
    r.key_code = KEY_UNUSED_LAST;
    {r.year, r.month, r.day, r.weekday, r.hour, r.minute, r.second} = '1;
    send_request(r);
    send_request(make_key(csmc_pkg::KEY_MENU));
    send_request(make_key(csmc_pkg::KEY_UP));
    send_request(make_key(csmc_pkg::KEY_CANCEL));
  endtask

  // Well-formed edit sessions: optional load, walk the menu with edits,
  // then either commit from the minute field or cancel part way.
  task automatic test_menu_sessions(input int unsigned item_goal);
    int unsigned sent;
    int unsigned quit_mode;
    int unsigned edits;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(($urandom_range(0, 4) == 0) ? make_raw_load() : make_time_load());
        sent++;
      end
      send_request(make_key(csmc_pkg::KEY_CANCEL));
      sent++;
      quit_mode = $urandom_range(csmc_pkg::MODE_YEAR, csmc_pkg::MODE_LAST + 3);
      for (int m = csmc_pkg::MODE_YEAR; m <= csmc_pkg::MODE_LAST; m++) begin
        send_request(make_key(csmc_pkg::KEY_MENU));
        sent++;
        edits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
        repeat (edits) begin
          send_request(make_key($urandom_range(0, 1) ? csmc_pkg::KEY_UP : csmc_pkg::KEY_DN));
          sent++;
          if ($urandom_range(0, 15) == 0) begin
            send_request(make_ignored_key());
            sent++;
          end
        end
        if (m == quit_mode) break;
      end
      send_request(make_key((quit_mode > csmc_pkg::MODE_LAST) ? csmc_pkg::KEY_MENU
                                                                : csmc_pkg::KEY_CANCEL));
      sent++;
    end
  endtask

  task automatic test_raw_noise(input int unsigned item_goal);
    csmc_pkg::req_t r;
    int unsigned    sent;
    sent = 0;
    while (sent < item_goal) begin
      r = make_raw_load();
      r.req_type = 1'($urandom_range(0, 1));
      send_request(r);
      sent++;
    end
  endtask

  task automatic test_full_rate(input int unsigned item_goal);
    idle_on = 1'b0;
    test_menu_sessions(item_goal);
  endtask

  initial begin
    clock_now = '{mode: csmc_pkg::MODE_NORMAL, year: csmc_pkg::RST_YEAR,
                  month: csmc_pkg::RST_MONTH, day: csmc_pkg::RST_DAY,
                  weekday: csmc_pkg::RST_WEEKDAY, hour: csmc_pkg::RST_HOUR,
                  minute: csmc_pkg::RST_MINUTE, second: csmc_pkg::RST_SECOND,
                  commit: 1'b0};
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_KEY;
    in_key_code     <= KEY_NONE;
    in_load_year    <= '0;
    in_load_month   <= '0;
    in_load_day     <= '0;
    in_load_weekday <= '0;
    in_load_hour    <= '0;
    in_load_minute  <= '0;
    in_load_second  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_ignored_keys();
    test_field_wrap();
    test_invalid_bcd();
    test_menu_sessions(480);
    // hold the sender until every pending readout has come back
    drain_results();
    test_raw_noise(170);
    test_full_rate(180);

    drain_results();
    repeat (8) @(posedge clk);
    if (bad_fields == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/csmc_pkg.sv
rtl/csmc_in_reg.sv
rtl/csmc_field_step.sv
rtl/csmc_state.sv
rtl/clock_set_menu_controller_top.sv
verif/testbench.sv
